/* rtl/smsp_pkg.sv */
// Package for the stereo mid/side fixed predictor core.
// Holds widths, beat structs, lane control struct and the residual fold function.
// No dependencies.
package smsp_pkg;

    localparam int SAMPLE_BITS    = 16;
    localparam int LANE_BITS      = SAMPLE_BITS + 1;
    localparam int RES_BITS       = SAMPLE_BITS + 6;
    localparam int MID_CODE_BITS  = SAMPLE_BITS + 4;
    localparam int SIDE_CODE_BITS = SAMPLE_BITS + 5;
    localparam int HIST_DEPTH     = 4;
    localparam int ORDER_BITS     = 3;

    localparam logic [ORDER_BITS-1:0] ORDER_0   = ORDER_BITS'(0);
    localparam logic [ORDER_BITS-1:0] ORDER_1   = ORDER_BITS'(1);
    localparam logic [ORDER_BITS-1:0] ORDER_2   = ORDER_BITS'(2);
    localparam logic [ORDER_BITS-1:0] ORDER_3   = ORDER_BITS'(3);
    localparam logic [ORDER_BITS-1:0] MAX_ORDER = ORDER_BITS'(4);

    typedef struct packed {
        logic signed [SAMPLE_BITS-1:0] left_in;
        logic signed [SAMPLE_BITS-1:0] right_in;
    } t_in_beat;

    typedef struct packed {
        logic [MID_CODE_BITS-1:0]  mid_code;
        logic [SIDE_CODE_BITS-1:0] side_code;
    } t_out_beat;

    typedef struct packed {
        logic                  shift;
        logic [ORDER_BITS-1:0] order;
    } t_lane_ctl;

    // zigzag: r >= 0 -> 2r, r < 0 -> 2(~r)+1
    function automatic logic [RES_BITS-1:0] fold_res(input logic signed [RES_BITS-1:0] res);
        logic [RES_BITS-1:0] mag;
        mag = res[RES_BITS-1] ? ~res : res;
        return {mag[RES_BITS-2:0], res[RES_BITS-1]};
    endfunction

endpackage

/* rtl/smsp_lane.sv */
// Predictor lane: four-deep history and fixed polynomial residual for one channel.
// Depends on smsp_pkg.
module smsp_lane (
    input  logic                                   i_clk,
    input  logic                                   i_rst_n,
    input  smsp_pkg::t_lane_ctl                    i_ctl,
    input  logic signed [smsp_pkg::LANE_BITS-1:0]  i_sample,
    output logic signed [smsp_pkg::RES_BITS-1:0]   o_residual
);
    import smsp_pkg::*;

    logic signed [LANE_BITS-1:0] r_hist [HIST_DEPTH];
    logic signed [RES_BITS-1:0]  x, h0, h1, h2, h3;

    always_comb begin
        x  = RES_BITS'(i_sample);
        h0 = RES_BITS'(r_hist[0]);
        h1 = RES_BITS'(r_hist[1]);
        h2 = RES_BITS'(r_hist[2]);
        h3 = RES_BITS'(r_hist[3]);
        case (i_ctl.order)
            ORDER_0: o_residual = x;
            ORDER_1: o_residual = x - h0;
            ORDER_2: o_residual = x - (h0 <<< 1) + h1;
            ORDER_3: o_residual = x - ((h0 <<< 1) + h0) + ((h1 <<< 1) + h1) - h2;
            default: o_residual = x - (h0 <<< 2) + ((h1 <<< 2) + (h1 <<< 1))
                                  - (h2 <<< 2) + h3;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < HIST_DEPTH; i++) begin
                r_hist[i] <= '0;
            end
        end else if (i_ctl.shift) begin
            r_hist[0] <= i_sample;
            for (int i = 1; i < HIST_DEPTH; i++) begin
                r_hist[i] <= r_hist[i-1];
            end
        end
    end

endmodule

/* rtl/smsp_merge.sv */
// Merge stage: folds both lane residuals, saturates to code widths, holds the output beat.
// Depends on smsp_pkg.
module smsp_merge (
    input  logic                                  i_clk,
    input  logic                                  i_rst_n,
    input  logic                                  i_load,
    input  logic signed [smsp_pkg::RES_BITS-1:0]  i_mid_res,
    input  logic signed [smsp_pkg::RES_BITS-1:0]  i_side_res,
    output logic                                  o_in_ready,
    output logic                                  o_out_valid,
    input  logic                                  i_out_ready,
    output smsp_pkg::t_out_beat                   o_out_data
);
    import smsp_pkg::*;

    logic                r_valid;
    t_out_beat           r_data;
    logic                n_valid;
    t_out_beat           n_data;
    logic [RES_BITS-1:0] mid_fold, side_fold;

    always_comb begin
        mid_fold  = fold_res(i_mid_res);
        side_fold = fold_res(i_side_res);
        n_data.mid_code  = (|mid_fold[RES_BITS-1:MID_CODE_BITS]) ? '1
                                                                 : mid_fold[MID_CODE_BITS-1:0];
        n_data.side_code = (|side_fold[RES_BITS-1:SIDE_CODE_BITS]) ? '1
                                                                   : side_fold[SIDE_CODE_BITS-1:0];
        n_valid = i_load | (r_valid & ~i_out_ready);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= n_valid;
        end
        if (i_load) begin
            r_data <= n_data;
        end
    end

    assign o_in_ready  = ~r_valid | i_out_ready;
    assign o_out_valid = r_valid;
    assign o_out_data  = r_data;

endmodule

/* rtl/stereo_mid_side_fixed_predictor_core.sv */
// Top level of the stereo mid/side fixed predictor: mid/side split, warm-up order,
// two predictor lanes and the merge stage. Depends on smsp_pkg, smsp_lane, smsp_merge.
//
//  channel | valid       | ready       | payload
//  --------+-------------+-------------+--------------------------
//  in      | i_in_valid  | o_in_ready  | i_in_data  (t_in_beat)
//  out     | o_out_valid | i_out_ready | o_out_data (t_out_beat)
//
// One beat per cycle unless the output stalls; the result appears in the cycle after the input beat is taken.
// Prediction and fold are done in the cycle of acceptance, the merge register holds the beat.
// Input is taken whenever the output register is empty or drains in the same cycle.
// Synchronous reset clears histories, warm-up count and output valid.
module stereo_mid_side_fixed_predictor_core (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_in_valid,
    output logic                o_in_ready,
    input  smsp_pkg::t_in_beat  i_in_data,
    output logic                o_out_valid,
    input  logic                i_out_ready,
    output smsp_pkg::t_out_beat o_out_data
);
    import smsp_pkg::*;

    logic                        accept;
    logic [ORDER_BITS-1:0]       r_warm;
    logic signed [LANE_BITS-1:0] left_s, right_s, sum, mid, side;
    logic signed [RES_BITS-1:0]  mid_res, side_res;
    t_lane_ctl                   ctl;

    assign accept = i_in_valid & o_in_ready;

    always_comb begin
        left_s  = LANE_BITS'(signed'(i_in_data.left_in[SAMPLE_BITS-1:0]));
        right_s = LANE_BITS'(signed'(i_in_data.right_in[SAMPLE_BITS-1:0]));
        sum     = left_s + right_s;
        mid     = sum >>> 1;
        side    = left_s - right_s;
        ctl.shift = accept;
        ctl.order = r_warm;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_warm <= ORDER_0;
        end else if (accept && r_warm < MAX_ORDER) begin
            r_warm <= r_warm + ORDER_1;
        end
    end

    smsp_lane u_mid_lane (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_ctl      (ctl),
        .i_sample   (mid),
        .o_residual (mid_res)
    );

    smsp_lane u_side_lane (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_ctl      (ctl),
        .i_sample   (side),
        .o_residual (side_res)
    );

    smsp_merge u_merge (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_load      (accept),
        .i_mid_res   (mid_res),
        .i_side_res  (side_res),
        .o_in_ready  (o_in_ready),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_out_data  (o_out_data)
    );

endmodule
